// ----- hw/rtl/lei_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lei_pkg
// Shared types and constants of the Lorenz-63 forward Euler integrator.
// ----------------------------------------------------------------------------
package lei_pkg;

  localparam int FRAC_BITS  = 24;  // fraction bits of coordinates and coefficients
  localparam int COORD_W    = 32;
  localparam int COEF_W     = 31;
  localparam int DT_W       = 32;
  localparam int STEP_W     = 20;
  localparam int SUM_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // pass pipeline depth is the number of ring slots
  localparam int RING_DEPTH = 6;
  localparam int TAG_W      = 3;

  // derivative width and magnitude width
  localparam int D_W   = 42;
  localparam int MAG_W = D_W - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA  = 3'd0,
    REG_RHO    = 3'd1,
    REG_BETA   = 3'd2,
    REG_DT     = 3'd3,
    REG_STEPS  = 3'd4,
    REG_WSCALE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] sigma;
    logic [COEF_W-1:0] rho;
    logic [COEF_W-1:0] beta;
    logic [DT_W-1:0]   dt;
    logic [DT_W-1:0]   wscale;
  } cfg_t;

  // one item as it travels around the ring
  typedef struct packed {
    logic                      valid;
    logic                      fin;    // a pass with no step done: integral valid
    logic [TAG_W-1:0]          tag;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [STEP_W-1:0]         steps;
    logic signed [SUM_W-1:0]   wsum;
    logic signed [SUM_W-1:0]   integ;
    logic                      sat;
  } slot_t;

  // magnitude with sign put back
  function automatic logic signed [D_W-1:0] apply_sign(input logic [MAG_W-1:0] m,
                                                        input logic neg);
    logic signed [D_W-1:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] a);
    return a[COORD_W-1] ? COORD_W'(-a) : COORD_W'(a);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lei_pass.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lei_pass
// Six-stage datapath for one Euler step of one ring slot. Always advances.
// A slot with steps left does a step; one with none keeps its point and
// computes the weight integral.
// ----------------------------------------------------------------------------
module lei_pass (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lei_pkg::cfg_t  cfg_i,
  input  lei_pkg::slot_t slot_i,
  output lei_pkg::slot_t slot_o
);
  import lei_pkg::*;

  // ---------------- stage 1: products on the old point ----------------
  slot_t       s1_q;
  logic [62:0] p_sig_q, p_rho_q, p_beta_q;
  logic [63:0] p_xz_q, p_xy_q, p_wl_q;
  logic [47:0] p_wh_q;
  logic        n_sig_q, n_x_q, n_xz_q, n_xy_q, n_z_q, n_w_q;

  logic signed [COORD_W:0] yx;
  logic [COORD_W-1:0]      m_yx, m_x, m_y, m_z;
  logic [SUM_W-1:0]        m_w;

  always_comb begin
    yx   = COORD_W'(0) + (COORD_W+1)'(slot_i.y) - (COORD_W+1)'(slot_i.x);
    m_yx = yx[COORD_W] ? COORD_W'(-yx) : COORD_W'(yx);
    m_x  = mag32(slot_i.x);
    m_y  = mag32(slot_i.y);
    m_z  = mag32(slot_i.z);
    m_w  = slot_i.wsum[SUM_W-1] ? SUM_W'(-slot_i.wsum) : SUM_W'(slot_i.wsum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_sig_q  <= 63'(m_yx) * 63'(cfg_i.sigma);
    p_rho_q  <= 63'(m_x) * 63'(cfg_i.rho);
    p_beta_q <= 63'(m_z) * 63'(cfg_i.beta);
    p_xz_q   <= 64'(m_x) * 64'(m_z);
    p_xy_q   <= 64'(m_x) * 64'(m_y);
    p_wh_q   <= 48'(m_w[SUM_W-1:32]) * 48'(cfg_i.dt);
    p_wl_q   <= 64'(m_w[31:0]) * 64'(cfg_i.dt);
    n_sig_q  <= yx[COORD_W];
    n_x_q    <= slot_i.x[COORD_W-1];
    n_z_q    <= slot_i.z[COORD_W-1];
    n_xz_q   <= slot_i.x[COORD_W-1] ^ slot_i.z[COORD_W-1];
    n_xy_q   <= slot_i.x[COORD_W-1] ^ slot_i.y[COORD_W-1];
    n_w_q    <= slot_i.wsum[SUM_W-1];
  end

  // ---------------- stage 2: derivatives, integral ----------------
  slot_t                 s2_q;
  logic [MAG_W-1:0]      dm_q [3];
  logic                  dn_q [3];
  logic signed [D_W-1:0] d [3];
  logic signed [D_W-1:0] t_xz;
  logic [SUM_W-1:0]      r_w;
  slot_t                 s2_d;

  always_comb begin
    t_xz = apply_sign(MAG_W'(p_xz_q >> FRAC_BITS), n_xz_q);
    d[0] = apply_sign(MAG_W'(p_sig_q >> FRAC_BITS), n_sig_q);
    d[1] = apply_sign(MAG_W'(p_rho_q >> FRAC_BITS), n_x_q) - D_W'(s1_q.y) - t_xz;
    d[2] = apply_sign(MAG_W'(p_xy_q >> FRAC_BITS), n_xy_q)
         - apply_sign(MAG_W'(p_beta_q >> FRAC_BITS), n_z_q);
    r_w  = p_wh_q + SUM_W'(p_wl_q >> 32);
    s2_d = s1_q;
    s2_d.integ = n_w_q ? -$signed(r_w) : $signed(r_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dm_q[i] <= d[i][D_W-1] ? MAG_W'(-d[i]) : MAG_W'(d[i]);
      dn_q[i] <= d[i][D_W-1];
    end
  end

  // ---------------- stage 3: dt partial products ----------------
  slot_t       s3_q;
  logic [40:0] ph_q [3];
  logic [63:0] pl_q [3];
  logic        n3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ph_q[i] <= 41'(dm_q[i][MAG_W-1:32]) * 41'(cfg_i.dt);
      pl_q[i] <= 64'(dm_q[i][31:0]) * 64'(cfg_i.dt);
      n3_q[i] <= dn_q[i];
    end
  end

  // ---------------- stage 4: new point with clamp ----------------
  slot_t              s4_q, s4_d;
  logic [41:0]        inc [3];
  logic signed [43:0] nv [3];
  logic signed [COORD_W-1:0] old_c [3];
  logic signed [COORD_W-1:0] new_c [3];
  logic               csat;
  logic               act4;

  always_comb begin
    old_c[0] = s3_q.x;
    old_c[1] = s3_q.y;
    old_c[2] = s3_q.z;
    csat     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      inc[i] = 42'(ph_q[i]) + 42'(pl_q[i] >> 32);
      nv[i]  = 44'(old_c[i]) + (n3_q[i] ? -$signed({2'b0, inc[i]})
                                        : $signed({2'b0, inc[i]}));
      if (nv[i] > 44'sd2147483647) begin
        new_c[i] = 32'sh7FFFFFFF;
        csat     = 1'b1;
      end else if (nv[i] < -44'sd2147483648) begin
        new_c[i] = 32'sh80000000;
        csat     = 1'b1;
      end else begin
        new_c[i] = COORD_W'(nv[i]);
      end
    end
    act4 = (s3_q.steps != '0);
    s4_d = s3_q;
    if (act4) begin
      s4_d.x   = new_c[0];
      s4_d.y   = new_c[1];
      s4_d.z   = new_c[2];
      s4_d.sat = s3_q.sat | csat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else begin
      s4_q <= s4_d;
    end
  end

  // ---------------- stage 5: weight product ----------------
  slot_t       s5_q;
  logic [63:0] pw_q;
  logic        nw5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
    end else begin
      s5_q <= s4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q  <= 64'(mag32(s4_q.x)) * 64'(cfg_i.wscale);
    nw5_q <= s4_q.x[COORD_W-1];
  end

  // ---------------- stage 6: weight sum, step count ----------------
  slot_t              s6_q, s6_d;
  logic [39:0]        term;
  logic signed [49:0] ws;

  always_comb begin
    term = 40'(pw_q >> FRAC_BITS);
    ws   = 50'(s5_q.wsum) + (nw5_q ? -$signed({10'b0, term}) : $signed({10'b0, term}));
    s6_d = s5_q;
    if (s5_q.steps != '0) begin
      s6_d.steps = s5_q.steps - STEP_W'(1);
      s6_d.fin   = 1'b0;
      if (ws > 50'sd140737488355327) begin
        s6_d.wsum = 48'sh7FFFFFFFFFFF;
        s6_d.sat  = 1'b1;
      end else if (ws < -50'sd140737488355328) begin
        s6_d.wsum = 48'sh800000000000;
        s6_d.sat  = 1'b1;
      end else begin
        s6_d.wsum = SUM_W'(ws);
      end
    end else begin
      s6_d.fin = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_q <= '0;
    end else begin
      s6_q <= s6_d;
    end
  end

  assign slot_o = s6_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lorenz63_euler_integrator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lorenz63_euler_integrator
// Forward Euler integration of Lorenz-63 starting points in fixed point.
//
//   channel  dir  fields
//   s_axis   in   tdata: start_x, start_y, start_z
//   m_axis   out  tdata: end_x, end_y, end_z, weight_integral; tuser: saturated
//   cfg      in   register index, write data
//
// A word circulates in a six-slot ring; each trip through the six-stage step
// datapath does one Euler step while steps remain, and a final trip computes
// the weight integral. Up to six words are in flight at once, one per ring
// slot, and a new word enters whenever a free slot reaches the ring head.
// Results leave in input order. A stalled output keeps finished words
// circulating without change. Reset empties the ring and output register.
// ----------------------------------------------------------------------------
module lorenz63_euler_integrator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,   // start_x, start_y, start_z
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // end_x, end_y, end_z, weight_integral
  output logic          m_axis_tuser,   // saturated
  input  logic          cfg_we_i,
  input  logic [lei_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lei_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lei_pkg::*;

  // configuration registers
  cfg_t              cfg_q;
  logic [STEP_W-1:0] steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sigma  <= 31'd167772160;
      cfg_q.rho    <= 31'd469762048;
      cfg_q.beta   <= 31'd44739243;
      cfg_q.dt     <= 32'd8589935;
      cfg_q.wscale <= 32'd85899346;
      steps_q      <= 20'd20000;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SIGMA:  cfg_q.sigma  <= cfg_data_i[COEF_W-1:0];
        REG_RHO:    cfg_q.rho    <= cfg_data_i[COEF_W-1:0];
        REG_BETA:   cfg_q.beta   <= cfg_data_i[COEF_W-1:0];
        REG_DT:     cfg_q.dt     <= cfg_data_i;
        REG_STEPS:  steps_q      <= cfg_data_i[STEP_W-1:0];
        REG_WSCALE: cfg_q.wscale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ring head, exit and insert
  slot_t            head, entry;
  logic             exit_ok, insert;
  logic [TAG_W-1:0] in_tag_q, out_tag_q;

  always_comb begin
    exit_ok = head.valid && head.fin && (head.tag == out_tag_q)
              && (!m_axis_tvalid || m_axis_tready);
    s_axis_tready = !head.valid || exit_ok;
    insert = s_axis_tvalid && s_axis_tready;
    entry  = head;
    if (insert) begin
      entry.valid = 1'b1;
      entry.fin   = 1'b0;
      entry.tag   = in_tag_q;
      entry.x     = s_axis_tdata[31:0];
      entry.y     = s_axis_tdata[63:32];
      entry.z     = s_axis_tdata[95:64];
      entry.steps = steps_q;
      entry.wsum  = '0;
      entry.integ = '0;
      entry.sat   = 1'b0;
    end else if (exit_ok) begin
      entry.valid = 1'b0;
    end
  end

  lei_pass u_pass (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .slot_i (entry),
    .slot_o (head)
  );

  // order tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q  <= '0;
      out_tag_q <= '0;
    end else begin
      if (insert)  in_tag_q  <= in_tag_q + TAG_W'(1);
      if (exit_ok) out_tag_q <= out_tag_q + TAG_W'(1);
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exit_ok) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_ok) begin
      m_axis_tdata <= {head.integ, head.z, head.y, head.x};
      m_axis_tuser <= head.sat;
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Lorenz-63 forward Euler integrator. Starting
// points go in on the input stream; an in-bench fixed-point Euler model
// predicts each final point, weight integral and saturation flag that no
// directed row gives, and every output word is checked in order. Both
// stream sides idle at random; coefficients are changed between phases only.
// ----------------------------------------------------------------------------
module testbench;
  import lei_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [47:0] integ;
    logic               sat;
  } endpoint_t;

  typedef struct {
    int unsigned        steps;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 known;
    endpoint_t          want;
  } row_t;

  localparam wide_t MAX32 = 128'sd2147483647;
  localparam wide_t MIN32 = -128'sd2147483648;
  localparam wide_t MAX48 = 128'sd140737488355327;
  localparam wide_t MIN48 = -128'sd140737488355328;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // coefficient copies used by the predictor
  logic [30:0] sigma_q = 31'd167772160;
  logic [30:0] rho_q   = 31'd469762048;
  logic [30:0] beta_q  = 31'd44739243;
  logic [31:0] dt_q    = 32'd8589935;
  logic [19:0] steps_q = 20'd20000;
  logic [31:0] wscale_q = 32'd85899346;

  endpoint_t pending_ends[$];
  int        mismatches = 0;
  bit        steady = 1'b0;

  lorenz63_euler_integrator dut (.*);

  always #5 clk_i = ~clk_i;

  // (a * b) >> sh, rounded toward zero
  function automatic wide_t mul_trunc(wide_t a, wide_t b, int sh);
    wide_t m;
    m = a < 0 ? -a : a;
    m = (m * b) >> sh;
    return a < 0 ? -m : m;
  endfunction

  function automatic wide_t clip(wide_t v, wide_t lo, wide_t hi, inout logic sat);
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // run the full Euler loop for one starting point
  function automatic endpoint_t integrate(logic signed [31:0] sx, logic signed [31:0] sy,
                                          logic signed [31:0] sz);
    wide_t x, y, z, dx, dy, dz, nx, ny, nz, wsum, mag_y, mag_z, ig;
    wide_t sg, rh, bt, dt, ws;
    logic sat;
    endpoint_t r;
    x = sx; y = sy; z = sz;
    sg = sigma_q; rh = rho_q; bt = beta_q; dt = dt_q; ws = wscale_q;
    wsum = 0;
    sat = 1'b0;
    for (int unsigned i = 0; i < steps_q; i++) begin
      mag_y = y < 0 ? -y : y;
      mag_z = z < 0 ? -z : z;
      dx = mul_trunc(y - x, sg, FRAC_BITS);
      dy = mul_trunc(x, rh, FRAC_BITS) - y
         - (z < 0 ? -mul_trunc(x, mag_z, FRAC_BITS) : mul_trunc(x, mag_z, FRAC_BITS));
      dz = (y < 0 ? -mul_trunc(x, mag_y, FRAC_BITS) : mul_trunc(x, mag_y, FRAC_BITS))
         - mul_trunc(z, bt, FRAC_BITS);
      nx = clip(x + mul_trunc(dx, dt, 32), MIN32, MAX32, sat);
      ny = clip(y + mul_trunc(dy, dt, 32), MIN32, MAX32, sat);
      nz = clip(z + mul_trunc(dz, dt, 32), MIN32, MAX32, sat);
      x = nx; y = ny; z = nz;
      wsum = clip(wsum + mul_trunc(x, ws, FRAC_BITS), MIN48, MAX48, sat);
    end
    r.x = x[31:0];
    r.y = y[31:0];
    r.z = z[31:0];
    ig = mul_trunc(wsum, dt, 32);
    r.integ = ig[47:0];
    r.sat = sat;
    return r;
  endfunction

  // write one coefficient register; call only while the block is idle
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SIGMA:  sigma_q  = val[30:0];
      REG_RHO:    rho_q    = val[30:0];
      REG_BETA:   beta_q   = val[30:0];
      REG_DT:     dt_q     = val;
      REG_STEPS:  steps_q  = val[19:0];
      REG_WSCALE: wscale_q = val;
      default: ;
    endcase
    // let the block sit quiet after each write
    @(posedge clk_i);
  endtask

  // hold the input quiet until every pending word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_ends.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // offer one starting point; queue its expected word on acceptance
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit known, endpoint_t want);
    while (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_ends.push_back(known ? want : integrate(x, y, z));
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(1) == 0) return $urandom();
    return $signed($urandom_range(80 << 24)) - (40 << 24);
  endfunction

  // accept output words and compare with the oldest expectation
  always @(posedge clk_i) begin
    endpoint_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_ends.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        e = pending_ends.pop_front();
        if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[63:32] !== e.y ||
            m_axis_tdata[95:64] !== e.z || m_axis_tdata[143:96] !== e.integ ||
            m_axis_tuser !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want x=%h y=%h z=%h int=%h sat=%b, got %h sat=%b",
                     e.x, e.y, e.z, e.integ, e.sat, m_axis_tdata, m_axis_tuser);
        end
      end
    end
    if (rst_ni) m_axis_tready <= steady || ($urandom_range(99) >= 30);
  end

  initial begin
    #20ms;
    $display("lorenz63_euler_integrator test failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    endpoint_t none;
    logic signed [31:0] cx, cy, cz;
    none = '{default: '0};

    // directed rows: default run, zero-step passthrough, extremes
    rows.push_back('{20000, 32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, 0, none});
    rows.push_back('{0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 1,
                     '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 48'sh0, 1'b0}});
    rows.push_back('{0, 32'sh8000_0000, 32'sh7fff_ffff, -32'sh1, 1,
                     '{32'sh8000_0000, 32'sh7fff_ffff, -32'sh1, 48'sh0, 1'b0}});
    rows.push_back('{0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 1,
                     '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678, 48'sh0, 1'b0}});
    rows.push_back('{5, 32'sh0, 32'sh0, 32'sh0, 1, '{32'sh0, 32'sh0, 32'sh0, 48'sh0, 1'b0}});
    rows.push_back('{5, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, none});
    rows.push_back('{5, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, none});
    rows.push_back('{5, 32'sh1, -32'sh1, 32'sh1, 0, none});
    rows.push_back('{5, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, none});
    rows.push_back('{5, -32'sh0800_0000, 32'sh0a00_0000, 32'sh1400_0000, 0, none});
    rows.push_back('{1, 32'sh0100_0000, 32'sh0, 32'sh0, 0, none});
    rows.push_back('{1, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shedcb_a987, 0, none});
    rows.push_back('{2, 32'sh0a00_0000, -32'sh0a00_0000, 32'sh1e00_0000, 0, none});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table; switch step count only with the block idle
    foreach (rows[i]) begin
      r = rows[i];
      if (r.steps != steps_q) begin
        drain();
        write_reg(REG_STEPS, r.steps);
      end
      send_point(r.x, r.y, r.z, r.known, r.want);
    end
    drain();

    // random phases; the first two hit the coefficient extremes
    for (int ph = 0; ph < 9; ph++) begin
      steady = (ph == 4);
      if (ph == 0) begin
        write_reg(REG_SIGMA, 32'h7fff_ffff);
        write_reg(REG_RHO, 32'h7fff_ffff);
        write_reg(REG_BETA, 32'h7fff_ffff);
        write_reg(REG_DT, 32'hffff_ffff);
        write_reg(REG_WSCALE, 32'hffff_ffff);
      end else if (ph == 1) begin
        write_reg(REG_SIGMA, 32'h0);
        write_reg(REG_RHO, 32'h0);
        write_reg(REG_BETA, 32'h0);
        write_reg(REG_DT, 32'h0);
        write_reg(REG_WSCALE, 32'h0);
      end else if (ph == 2) begin
        write_reg(REG_SIGMA, 32'd167772160);
        write_reg(REG_RHO, 32'd469762048);
        write_reg(REG_BETA, 32'd44739243);
        write_reg(REG_DT, $urandom_range(32'h0400_0000));
        write_reg(REG_WSCALE, 32'd85899346);
      end else begin
        write_reg(REG_SIGMA, $urandom_range(1) ? $urandom() : $urandom_range(20 << 24));
        write_reg(REG_RHO, $urandom_range(1) ? $urandom() : $urandom_range(40 << 24));
        write_reg(REG_BETA, $urandom_range(1) ? $urandom() : $urandom_range(4 << 24));
        write_reg(REG_DT, $urandom_range(1) ? $urandom() : $urandom_range(32'h0200_0000));
        write_reg(REG_WSCALE, $urandom());
      end
      write_reg(REG_STEPS, (ph == 8) ? 20'hfffff & 20'd0 : $urandom_range(1, 30));
      for (int k = 0; k < 11; k++) begin
        cx = rand_coord();
        cy = rand_coord();
        cz = rand_coord();
        send_point(cx, cy, cz, 1'b0, none);
        // hold off once until the block has emptied
        if (ph == 3 && k == 5) drain();
      end
      drain();
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("lorenz63_euler_integrator test passed");
    end else begin
      $display("lorenz63_euler_integrator test failed");
    end
    $finish;
  end

endmodule
